// ----- hw/rtl/ffd_pkg.sv -----
// Shared types, constants and fixed-point helpers for the lattice deformer.
package ffd_pkg;

    localparam int DEGREE_DEF = 2;
    localparam int COORD_W    = 32;
    localparam int FRAME_NUM  = 4;
    localparam int QDEPTH     = 2;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DOT_W      = 67;
    localparam int LEN_W      = 64;
    localparam int Q_W        = 34;
    localparam int FRAC_W     = 24;
    localparam int DIV_NUM_W  = DOT_W + FRAC_W;

    localparam logic [1:0] REQ_LAT    = 2'd0;
    localparam logic [1:0] REQ_FRAME  = 2'd1;
    localparam logic [1:0] REQ_DEFORM = 2'd2;

    localparam logic [1:0] FRAME_ORIGIN = 2'd0;

    localparam logic signed [COORD_W-1:0] Q24_ONE = 32'sh0100_0000;

    typedef enum logic [1:0] {KIND_LAT, KIND_FRAME, KIND_DEFORM} kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [4:0]                 slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DOT, ST_CHK, ST_DIV, ST_BERN, ST_WGT, ST_OUT
    } state_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [68:0] v);
        if (v > 69'sd2147483647)
            return 32'sh7fff_ffff;
        else if (v < -69'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[COORD_W-1:0];
    endfunction

    // Q8.24 product with round-half-up and saturation.
    function automatic logic signed [COORD_W-1:0] qmul(input logic signed [PROD_W-1:0] p);
        logic signed [68:0] t;
        t = (69'(p) + 69'sd8388608) >>> FRAC_W;
        return sat32(t);
    endfunction

    function automatic logic [1:0] binom(input logic [1:0] n, input logic [1:0] m);
        logic [1:0] r;
        r = 2'd1;
        if (n == 2'd3 && (m == 2'd1 || m == 2'd2))
            r = 2'd3;
        else if (n == 2'd2 && m == 2'd1)
            r = 2'd2;
        return r;
    endfunction

endpackage

// ----- hw/rtl/ffd_front.sv -----
// Front end: accepts requests, drops those that change nothing and classifies the rest.
module ffd_front
    import ffd_pkg::*;
#(
    parameter int DEGREE = DEGREE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 req_type,
    input  logic [4:0]                 slot,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    output logic                       push,
    output item_t                      push_item,
    input  logic                       q_full
);

    localparam int LAT_SIZE = (DEGREE + 1) * (DEGREE + 1) * (DEGREE + 1);

    logic   hold_vld_reg;
    logic   hold_vld_next;
    item_t  hold_reg;
    logic   keep;
    kind_t  kind;
    logic   take;

    always_comb
    begin
        keep = 1'b0;
        kind = KIND_DEFORM;
        unique case (req_type)
            REQ_LAT:
            begin
                keep = int'(slot) < LAT_SIZE;
                kind = KIND_LAT;
            end
            REQ_FRAME:
            begin
                keep = int'(slot) < FRAME_NUM;
                kind = KIND_FRAME;
            end
            REQ_DEFORM:
            begin
                keep = 1'b1;
                kind = KIND_DEFORM;
            end
            default:
            begin
                keep = 1'b0;
                kind = KIND_DEFORM;
            end
        endcase
    end

    assign push      = hold_vld_reg && !q_full;
    assign push_item = hold_reg;
    assign in_ready  = !hold_vld_reg || !q_full;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        if (take && keep)
            hold_vld_next = 1'b1;
        else if (push)
            hold_vld_next = 1'b0;
        else
            hold_vld_next = hold_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_vld_reg <= 1'b0;
        else
            hold_vld_reg <= hold_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && keep)
        begin
            hold_reg.kind <= kind;
            hold_reg.slot <= slot;
            hold_reg.x    <= coord_x;
            hold_reg.y    <= coord_y;
            hold_reg.z    <= coord_z;
        end
    end

endmodule

// ----- hw/rtl/ffd_queue.sv -----
// Small request queue between the front end and the execution unit.
module ffd_queue
    import ffd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output item_t  head
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    item_t            mem [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNTW'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- hw/rtl/ffd_div.sv -----
// Restoring bit-serial divider for the lattice coordinate projection.
module ffd_div
    import ffd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_NUM_W-1:0]  num,
    input  logic [LEN_W-1:0]      den,
    output logic                  done,
    output logic [Q_W-1:0]        quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [Q_W:0] QMAX = (Q_W + 1)'(1) << (Q_W - 1);

    logic                  run_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [LEN_W-1:0]      den_reg;
    logic [LEN_W-1:0]      r_reg;
    logic [Q_W-1:0]        q_reg;

    logic [LEN_W-1:0]      r_sh;
    logic                  ge;
    logic [LEN_W-1:0]      r_next;
    logic [Q_W:0]          q_sh;
    logic [Q_W-1:0]        q_next;

    // The quotient is clamped at 2^33, well past the saturation point.
    always_comb
    begin
        r_sh   = {r_reg[LEN_W-2:0], num_reg[DIV_NUM_W-1]};
        ge     = r_reg[LEN_W-1] || (r_sh >= den_reg);
        r_next = ge ? r_sh - den_reg : r_sh;
        q_sh   = {q_reg, ge};
        q_next = (q_sh >= QMAX) ? QMAX[Q_W-1:0] : q_sh[Q_W-1:0];
    end

    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_NUM_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            r_reg   <= r_next;
            q_reg   <= q_next;
        end
    end

endmodule

// ----- hw/rtl/ffd_back.sv -----
// Execution unit: table writes, projection, Bernstein weights and lattice accumulation.
module ffd_back
    import ffd_pkg::*;
#(
    parameter int DEGREE = DEGREE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  item_t                      q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_W-1:0]  out_x,
    output logic signed [COORD_W-1:0]  out_y,
    output logic signed [COORD_W-1:0]  out_z,
    output logic                       degenerate_axis
);

    localparam int N        = DEGREE + 1;
    localparam int LAT_SIZE = N * N * N;
    localparam int LAW      = $clog2(LAT_SIZE);
    localparam int CW       = (N > 1) ? $clog2(N) : 1;

    state_t state_reg;
    state_t state_next;

    logic             ph_reg;
    logic [2:0]       c_reg;
    logic [1:0]       ax_reg;
    logic [CW-1:0]    m_reg;
    logic [CW-1:0]    e_reg;
    logic [CW-1:0]    i_reg;
    logic [CW-1:0]    j_reg;
    logic [CW-1:0]    k_reg;
    logic [2:0]       sop_reg;
    logic             out_valid_reg;

    logic signed [COORD_W-1:0] fx_reg [FRAME_NUM];
    logic signed [COORD_W-1:0] fy_reg [FRAME_NUM];
    logic signed [COORD_W-1:0] fz_reg [FRAME_NUM];

    logic [3*COORD_W-1:0]   lat_mem [LAT_SIZE];
    logic [LAT_SIZE-1:0]    lat_vld_reg;
    logic [3*COORD_W-1:0]   lat_rd_reg;
    logic                   lat_rd_vld_reg;
    logic [LAW-1:0]         lat_wa;
    logic [LAW-1:0]         lat_ra;

    logic signed [COORD_W:0]    d_reg [3];
    logic signed [DOT_W-1:0]    dot_reg;
    logic [LEN_W-1:0]           len_reg;
    logic signed [COORD_W-1:0]  coord_reg;
    logic                       degen_reg;
    logic signed [COORD_W-1:0]  acc_reg;
    logic signed [COORD_W-1:0]  w_reg [3][N];
    logic signed [COORD_W-1:0]  t_reg;
    logic signed [63:0]         sum_reg [3];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic signed [COORD_W-1:0]  out_z_reg;
    logic                       out_degen_reg;

    logic signed [MUL_W-1:0]    opa;
    logic signed [MUL_W-1:0]    opb;
    logic                       div_start;
    logic                       div_done;
    logic [Q_W-1:0]             div_q;
    logic [DOT_W-1:0]           dot_mag;
    logic [1:0]                 cc;
    logic [1:0]                 fa;
    logic signed [COORD_W-1:0]  a_sel;
    logic signed [COORD_W-1:0]  lat_sel;
    logic signed [COORD_W-1:0]  omx;
    logic [1:0]                 bn;
    logic                       is_deform;
    logic                       out_free;
    logic                       e_last;
    logic                       m_last;
    logic                       idx_last;
    logic signed [68:0]         qs;

    assign cc        = c_reg[2:1];
    assign fa        = ax_reg + 2'd1;
    assign is_deform = q_valid && (q_item.kind == KIND_DEFORM);
    assign out_free  = !out_valid_reg || out_ready;
    assign e_last    = (e_reg == CW'(DEGREE));
    assign m_last    = (m_reg == CW'(DEGREE));
    assign idx_last  = (i_reg == CW'(DEGREE)) && (j_reg == CW'(DEGREE))
                       && (k_reg == CW'(DEGREE));
    assign omx       = sat32(69'sd16777216 - 69'(coord_reg));
    assign bn        = binom(2'(DEGREE), 2'(m_reg));
    assign dot_mag   = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : dot_reg;
    assign qs        = $signed({35'b0, div_q});
    assign lat_wa    = LAW'(q_item.slot);
    assign lat_ra    = LAW'((int'(i_reg) * N + int'(j_reg)) * N + int'(k_reg));

    always_comb
    begin
        unique case (cc)
            2'd0:    a_sel = fx_reg[fa];
            2'd1:    a_sel = fy_reg[fa];
            default: a_sel = fz_reg[fa];
        endcase
    end

    // Lattice entries never written read as zero.
    always_comb
    begin
        unique case (sop_reg)
            3'd2:    lat_sel = lat_rd_reg[COORD_W-1:0];
            3'd3:    lat_sel = lat_rd_reg[2*COORD_W-1:COORD_W];
            default: lat_sel = lat_rd_reg[3*COORD_W-1:2*COORD_W];
        endcase
        if (!lat_rd_vld_reg)
            lat_sel = '0;
    end

    ffd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({dot_mag, {FRAC_W{1'b0}}}),
        .den   (len_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (is_deform)
                    state_next = ST_DOT;
            ST_DOT:
                if (ph_reg && c_reg == 3'd5)
                    state_next = ST_CHK;
            ST_CHK:
                state_next = (len_reg == '0) ? ST_BERN : ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_BERN;
            ST_BERN:
                if (ph_reg && e_last && m_last)
                    state_next = (ax_reg == 2'd2) ? ST_WGT : ST_DOT;
            ST_WGT:
                if (ph_reg && sop_reg == 3'd4 && idx_last)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: queue pop, divider start and multiplier operands.
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        opa       = '0;
        opb       = '0;
        unique case (state_reg)
            ST_IDLE:
                q_pop = q_valid;
            ST_DOT:
            begin
                opa = c_reg[0] ? MUL_W'(a_sel) : MUL_W'(d_reg[cc]);
                opb = MUL_W'(a_sel);
            end
            ST_CHK:
                div_start = (len_reg != '0);
            ST_BERN:
            begin
                opa = MUL_W'(acc_reg);
                if (e_last)
                    opb = {{(MUL_W-2){1'b0}}, bn};
                else if (int'(e_reg) < DEGREE - int'(m_reg))
                    opb = MUL_W'(omx);
                else
                    opb = MUL_W'(coord_reg);
            end
            ST_WGT:
            begin
                if (sop_reg == 3'd0)
                begin
                    opa = MUL_W'(w_reg[0][i_reg]);
                    opb = MUL_W'(w_reg[1][j_reg]);
                end
                else if (sop_reg == 3'd1)
                begin
                    opa = MUL_W'(t_reg);
                    opb = MUL_W'(w_reg[2][k_reg]);
                end
                else
                begin
                    opa = MUL_W'(t_reg);
                    opb = MUL_W'(lat_sel);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= 1'b0;
            c_reg         <= '0;
            ax_reg        <= '0;
            m_reg         <= '0;
            e_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            sop_reg       <= '0;
            out_valid_reg <= 1'b0;
            lat_vld_reg   <= '0;
            for (int f = 0; f < FRAME_NUM; f++)
            begin
                fx_reg[f] <= '0;
                fy_reg[f] <= '0;
                fz_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DOT || state_reg == ST_BERN || state_reg == ST_WGT)
                ph_reg <= !ph_reg;
            else
                ph_reg <= 1'b0;

            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    c_reg  <= '0;
                    ax_reg <= '0;
                    if (q_valid && q_item.kind == KIND_LAT)
                        lat_vld_reg[lat_wa] <= 1'b1;
                    if (q_valid && q_item.kind == KIND_FRAME)
                    begin
                        fx_reg[q_item.slot[1:0]] <= q_item.x;
                        fy_reg[q_item.slot[1:0]] <= q_item.y;
                        fz_reg[q_item.slot[1:0]] <= q_item.z;
                    end
                end
                ST_DOT:
                    if (ph_reg)
                        c_reg <= c_reg + 3'd1;
                ST_CHK:
                begin
                    m_reg <= '0;
                    e_reg <= '0;
                end
                ST_BERN:
                    if (ph_reg)
                    begin
                        if (e_last)
                        begin
                            e_reg <= '0;
                            if (m_last)
                            begin
                                m_reg <= '0;
                                if (ax_reg == 2'd2)
                                begin
                                    i_reg   <= '0;
                                    j_reg   <= '0;
                                    k_reg   <= '0;
                                    sop_reg <= '0;
                                end
                                else
                                begin
                                    ax_reg <= ax_reg + 2'd1;
                                    c_reg  <= '0;
                                end
                            end
                            else
                                m_reg <= m_reg + 1'b1;
                        end
                        else
                            e_reg <= e_reg + 1'b1;
                    end
                ST_WGT:
                    if (ph_reg)
                    begin
                        if (sop_reg == 3'd4)
                        begin
                            sop_reg <= '0;
                            if (k_reg == CW'(DEGREE))
                            begin
                                k_reg <= '0;
                                if (j_reg == CW'(DEGREE))
                                begin
                                    j_reg <= '0;
                                    i_reg <= i_reg + 1'b1;
                                end
                                else
                                    j_reg <= j_reg + 1'b1;
                            end
                            else
                                k_reg <= k_reg + 1'b1;
                        end
                        else
                            sop_reg <= sop_reg + 3'd1;
                    end
                default:
                begin
                    c_reg <= c_reg;
                end
            endcase
        end
    end

    // Lattice table: one write port for table loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_item.kind == KIND_LAT)
            lat_mem[lat_wa] <= {q_item.z, q_item.y, q_item.x};
        lat_rd_reg     <= lat_mem[lat_ra];
        lat_rd_vld_reg <= lat_vld_reg[lat_ra];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        unique case (state_reg)
            ST_IDLE:
                if (is_deform)
                begin
                    d_reg[0]  <= (COORD_W+1)'(q_item.x) - (COORD_W+1)'(fx_reg[FRAME_ORIGIN]);
                    d_reg[1]  <= (COORD_W+1)'(q_item.y) - (COORD_W+1)'(fy_reg[FRAME_ORIGIN]);
                    d_reg[2]  <= (COORD_W+1)'(q_item.z) - (COORD_W+1)'(fz_reg[FRAME_ORIGIN]);
                    dot_reg   <= '0;
                    len_reg   <= '0;
                    degen_reg <= 1'b0;
                    for (int c = 0; c < 3; c++)
                        sum_reg[c] <= '0;
                end
            ST_DOT:
                if (ph_reg)
                begin
                    if (c_reg[0])
                        len_reg <= len_reg + prod_reg[LEN_W-1:0];
                    else
                        dot_reg <= dot_reg + DOT_W'($signed(prod_reg[64:0]));
                end
            ST_CHK:
            begin
                acc_reg <= Q24_ONE;
                if (len_reg == '0)
                begin
                    coord_reg <= '0;
                    degen_reg <= 1'b1;
                end
            end
            ST_DIV:
                if (div_done)
                begin
                    coord_reg <= sat32(dot_reg[DOT_W-1] ? -qs : qs);
                    acc_reg   <= Q24_ONE;
                end
            ST_BERN:
                if (ph_reg)
                begin
                    if (e_last)
                    begin
                        w_reg[ax_reg][m_reg] <= sat32(69'(prod_reg));
                        acc_reg              <= Q24_ONE;
                    end
                    else
                        acc_reg <= qmul(prod_reg);
                    // The next axis starts its dot products from zero.
                    if (e_last && m_last)
                    begin
                        dot_reg <= '0;
                        len_reg <= '0;
                    end
                end
            ST_WGT:
                if (ph_reg)
                begin
                    if (sop_reg == 3'd0 || sop_reg == 3'd1)
                        t_reg <= qmul(prod_reg);
                    else if (sop_reg == 3'd2)
                        sum_reg[0] <= sum_reg[0] + 64'(prod_reg >>> 8);
                    else if (sop_reg == 3'd3)
                        sum_reg[1] <= sum_reg[1] + 64'(prod_reg >>> 8);
                    else
                        sum_reg[2] <= sum_reg[2] + 64'(prod_reg >>> 8);
                end
            ST_OUT:
                if (out_free)
                begin
                    out_x_reg     <= sat32((69'(sum_reg[0]) + 69'sd32768) >>> 16);
                    out_y_reg     <= sat32((69'(sum_reg[1]) + 69'sd32768) >>> 16);
                    out_z_reg     <= sat32((69'(sum_reg[2]) + 69'sd32768) >>> 16);
                    out_degen_reg <= degen_reg;
                end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign out_x           = out_x_reg;
    assign out_y           = out_y_reg;
    assign out_z           = out_z_reg;
    assign degenerate_axis = out_degen_reg;

endmodule

// ----- hw/rtl/ffd_bezier_vertex_deform.sv -----
// A deform request is offered on out_valid after its three axes are projected and weighted and
// every lattice entry is accumulated; a zero-length axis skips its divide. Table writes pass
// through the front holding register and the queue and land while the execution unit is idle.
// One deform completes before the next is popped; throughput is set by the 91-step serial divider
// per axis and the single shared multiplier that walks every lattice entry five times.
// Reset clears the lattice and frame tables (via valid bits for the lattice), the queue
// and all control state; the block accepts requests from the first cycle after reset.
module ffd_bezier_vertex_deform
    import ffd_pkg::*;
#(
    parameter int DEGREE = DEGREE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 req_type,
    input  logic [4:0]                 slot,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_W-1:0]  out_x,
    output logic signed [COORD_W-1:0]  out_y,
    output logic signed [COORD_W-1:0]  out_z,
    output logic                       degenerate_axis
);

    logic   push;
    item_t  push_item;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    item_t  q_head;

    ffd_front #(.DEGREE(DEGREE)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .slot      (slot),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    ffd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    ffd_back #(.DEGREE(DEGREE)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .degenerate_axis (degenerate_axis)
    );

endmodule

// ----- hw/rtl/ffd_checker.sv -----
// Port-level checker for the deformer, bound to the top level.
module ffd_checker
    import ffd_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [1:0]                 req_type,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [COORD_W-1:0]  out_x,
    input logic signed [COORD_W-1:0]  out_y,
    input logic signed [COORD_W-1:0]  out_z,
    input logic                       degenerate_axis
);

    logic [3:0] pend_reg;
    logic       inc;
    logic       dec;

    assign inc = in_valid && in_ready && (req_type == REQ_DEFORM);
    assign dec = out_valid && out_ready;

    // Deform requests in flight: front stage, queue, execution unit and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (inc && !dec)
            pend_reg <= pend_reg + 4'd1;
        else if (dec && !inc)
            pend_reg <= pend_reg - 4'd1;
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
        && $stable(out_z) && $stable(degenerate_axis))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result without a deform request");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'd5)
        else $error("more deform requests in flight than the block can hold");

endmodule

bind ffd_bezier_vertex_deform ffd_checker u_ffd_checker (.*);
